@@ rtl/obb_pkg.sv @@
package obb_pkg;

    localparam int AX_W    = 16;
    localparam int CEN_W   = 20;
    localparam int HALF_W  = 16;
    localparam int D_W     = CEN_W + 1;
    localparam int PROD_W  = 2 * AX_W;
    localparam int V_W     = PROD_W + 1;
    localparam int SQ_W    = 64;
    localparam int VDP_W   = V_W + D_W;
    localparam int VD_W    = VDP_W + 2;
    localparam int LEN_W   = VD_W - 2;
    localparam int ADP_W   = AX_W + V_W - 1;
    localparam int DOT_W   = ADP_W + 2;
    localparam int MAG_W   = DOT_W - 2;
    localparam int TERM_W  = MAG_W + HALF_W;
    localparam int FRAC_SH = 14;
    localparam int RAD_W   = TERM_W - FRAC_SH + 2;
    localparam int RSUM_W  = RAD_W + 1;
    localparam int OVL_W   = LEN_W + 2;
    localparam int BEST_W  = RSUM_W;
    localparam int DEPTH_W = 28;
    localparam int DEPTH_SH = 20;
    localparam int IDX_W   = 4;
    localparam int NUM_AXES = 15;
    localparam int CELL_STAGES = 6;

    localparam logic [SQ_W-1:0] AXIS_EPS_SQ = 64'd72057594038;
    localparam logic [IDX_W-1:0] FIRST_B_AXIS = 4'd3;
    localparam logic [IDX_W-1:0] FIRST_CROSS_AXIS = 4'd6;

    typedef struct packed {
        logic [3*CEN_W-1:0] a_center;
        logic [3*AX_W-1:0]  a_axis_x;
        logic [3*AX_W-1:0]  a_axis_y;
        logic [3*AX_W-1:0]  a_axis_z;
        logic [3*HALF_W-1:0] a_half_size;
        logic [3*CEN_W-1:0] b_center;
        logic [3*AX_W-1:0]  b_axis_x;
        logic [3*AX_W-1:0]  b_axis_y;
        logic [3*AX_W-1:0]  b_axis_z;
        logic [3*HALF_W-1:0] b_half_size;
    } pair_in_t;

    typedef struct packed {
        logic                 boxes_overlap;
        logic                 depth_valid;
        logic [DEPTH_W-1:0]   min_depth;
        logic [IDX_W-1:0]     min_axis_index;
    } result_t;

    typedef struct packed {
        logic [2:0][2:0][AX_W-1:0] aa;
        logic [2:0][2:0][AX_W-1:0] ba;
        logic [2:0][HALF_W-1:0]    ha;
        logic [2:0][HALF_W-1:0]    hb;
        logic [2:0][D_W-1:0]       d;
    } pair_t;

    typedef struct packed {
        logic              apart;
        logic              have;
        logic [BEST_W-1:0] best;
        logic [IDX_W-1:0]  idx;
    } run_t;

    function automatic logic [1:0] face_index(input logic [IDX_W-1:0] id);
        logic [IDX_W-1:0] t;
        begin
            t = (id < FIRST_B_AXIS) ? id : id - FIRST_B_AXIS;
            return t[1:0];
        end
    endfunction

    function automatic logic [1:0] cross_i(input logic [IDX_W-1:0] id);
        logic [1:0] r;
        begin
            unique case (id)
                4'd6, 4'd7, 4'd8:    r = 2'd0;
                4'd9, 4'd10, 4'd11:  r = 2'd1;
                4'd12, 4'd13, 4'd14: r = 2'd2;
                default:             r = 2'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [1:0] cross_j(input logic [IDX_W-1:0] id);
        logic [1:0] r;
        begin
            unique case (id)
                4'd6, 4'd9, 4'd12:   r = 2'd0;
                4'd7, 4'd10, 4'd13:  r = 2'd1;
                4'd8, 4'd11, 4'd14:  r = 2'd2;
                default:             r = 2'd0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ rtl/obb_prep.sv @@
module obb_prep (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  obb_pkg::pair_in_t in_data,
    output logic             out_valid,
    output obb_pkg::pair_t   out_pair
);
    import obb_pkg::*;

    logic  valid_reg;
    pair_t pair_reg;
    pair_t pair_next;

    always_comb
    begin
        pair_next.aa[0] = in_data.a_axis_x;
        pair_next.aa[1] = in_data.a_axis_y;
        pair_next.aa[2] = in_data.a_axis_z;
        pair_next.ba[0] = in_data.b_axis_x;
        pair_next.ba[1] = in_data.b_axis_y;
        pair_next.ba[2] = in_data.b_axis_z;
        pair_next.ha    = in_data.a_half_size;
        pair_next.hb    = in_data.b_half_size;
        for (int k = 0; k < 3; k++)
        begin
            pair_next.d[k] =
                D_W'($signed(in_data.b_center[k*CEN_W +: CEN_W]))
                - D_W'($signed(in_data.a_center[k*CEN_W +: CEN_W]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pair_reg <= pair_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pair  = pair_reg;

endmodule

@@ rtl/obb_cell.sv @@
module obb_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [obb_pkg::IDX_W-1:0]   axis_id,
    input  logic                        in_valid,
    input  obb_pkg::pair_t              in_pair,
    input  obb_pkg::run_t               in_run,
    output logic                        out_valid,
    output obb_pkg::pair_t              out_pair,
    output obb_pkg::run_t               out_run
);
    import obb_pkg::*;

    logic [CELL_STAGES-1:0] vld_reg;
    pair_t pair_reg [CELL_STAGES];
    run_t  run_reg  [CELL_STAGES];

    logic              is_face;
    logic              face_b;
    logic [1:0]        fidx;
    logic [1:0]        ci;
    logic [1:0]        cj;

    logic signed [PROD_W-1:0] xp_next [6];
    logic signed [PROD_W-1:0] xp_reg  [6];
    logic [2:0][AX_W-1:0]     fvec_next;
    logic [2:0][AX_W-1:0]     fvec_reg;

    logic signed [V_W-1:0] v_next [3];
    logic signed [V_W-1:0] v_reg  [3];

    logic [SQ_W-1:0]          sq_next  [3];
    logic [SQ_W-1:0]          sq_reg   [3];
    logic signed [VDP_W-1:0]  vdp_next [3];
    logic signed [VDP_W-1:0]  vdp_reg  [3];
    logic signed [ADP_W-1:0]  adp_next [3][3];
    logic signed [ADP_W-1:0]  adp_reg  [3][3];
    logic signed [ADP_W-1:0]  bdp_next [3][3];
    logic signed [ADP_W-1:0]  bdp_reg  [3][3];

    logic [SQ_W-1:0]          lsq_next;
    logic [SQ_W-1:0]          lsq_reg;
    logic signed [VD_W-1:0]   vd_next;
    logic signed [VD_W-1:0]   vd_reg;
    logic signed [DOT_W-1:0]  adot_next [3];
    logic signed [DOT_W-1:0]  adot_reg  [3];
    logic signed [DOT_W-1:0]  bdot_next [3];
    logic signed [DOT_W-1:0]  bdot_reg  [3];

    logic                     skip_next;
    logic                     skip_reg;
    logic [LEN_W-1:0]         len_next;
    logic [LEN_W-1:0]         len_reg;
    logic [TERM_W-1:0]        ta_next [3];
    logic [TERM_W-1:0]        ta_reg  [3];
    logic [TERM_W-1:0]        tb_next [3];
    logic [TERM_W-1:0]        tb_reg  [3];

    run_t run_next;

    always_comb
    begin
        is_face = axis_id < FIRST_CROSS_AXIS;
        face_b  = axis_id >= FIRST_B_AXIS;
        fidx    = face_index(axis_id);
        ci      = cross_i(axis_id);
        cj      = cross_j(axis_id);
    end

    always_comb
    begin
        fvec_next = face_b ? in_pair.ba[fidx] : in_pair.aa[fidx];
        xp_next[0] = $signed(in_pair.aa[ci][1]) * $signed(in_pair.ba[cj][2]);
        xp_next[1] = $signed(in_pair.aa[ci][2]) * $signed(in_pair.ba[cj][1]);
        xp_next[2] = $signed(in_pair.aa[ci][2]) * $signed(in_pair.ba[cj][0]);
        xp_next[3] = $signed(in_pair.aa[ci][0]) * $signed(in_pair.ba[cj][2]);
        xp_next[4] = $signed(in_pair.aa[ci][0]) * $signed(in_pair.ba[cj][1]);
        xp_next[5] = $signed(in_pair.aa[ci][1]) * $signed(in_pair.ba[cj][0]);
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (is_face)
            begin
                v_next[k] = V_W'($signed(fvec_reg[k])) <<< FRAC_SH;
            end
            else
            begin
                v_next[k] = V_W'(xp_reg[2*k]) - V_W'(xp_reg[2*k+1]);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_next[k]  = SQ_W'(v_reg[k]) * SQ_W'(v_reg[k]);
            vdp_next[k] = v_reg[k] * $signed(pair_reg[1].d[k]);
            for (int m = 0; m < 3; m++)
            begin
                adp_next[m][k] = $signed(pair_reg[1].aa[m][k]) * v_reg[k];
                bdp_next[m][k] = $signed(pair_reg[1].ba[m][k]) * v_reg[k];
            end
        end
    end

    always_comb
    begin
        lsq_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
        vd_next  = VD_W'(vdp_reg[0]) + VD_W'(vdp_reg[1]) + VD_W'(vdp_reg[2]);
        for (int m = 0; m < 3; m++)
        begin
            adot_next[m] = DOT_W'(adp_reg[m][0]) + DOT_W'(adp_reg[m][1])
                           + DOT_W'(adp_reg[m][2]);
            bdot_next[m] = DOT_W'(bdp_reg[m][0]) + DOT_W'(bdp_reg[m][1])
                           + DOT_W'(bdp_reg[m][2]);
        end
    end

    always_comb
    begin
        logic [DOT_W-1:0] amag;
        logic [DOT_W-1:0] bmag;
        logic [VD_W-1:0]  vmag;
        skip_next = lsq_reg < AXIS_EPS_SQ;
        vmag      = vd_reg[VD_W-1] ? VD_W'(-vd_reg) : VD_W'(vd_reg);
        len_next  = vmag[LEN_W-1:0];
        for (int m = 0; m < 3; m++)
        begin
            amag = adot_reg[m][DOT_W-1] ? DOT_W'(-adot_reg[m]) : DOT_W'(adot_reg[m]);
            bmag = bdot_reg[m][DOT_W-1] ? DOT_W'(-bdot_reg[m]) : DOT_W'(bdot_reg[m]);
            ta_next[m] = TERM_W'(amag[MAG_W-1:0]) * TERM_W'(pair_reg[3].ha[m]);
            tb_next[m] = TERM_W'(bmag[MAG_W-1:0]) * TERM_W'(pair_reg[3].hb[m]);
        end
    end

    always_comb
    begin
        logic [RAD_W-1:0]        ra;
        logic [RAD_W-1:0]        rb;
        logic [RSUM_W-1:0]       rsum;
        logic signed [OVL_W-1:0] ovl;
        ra = '0;
        rb = '0;
        for (int m = 0; m < 3; m++)
        begin
            ra = ra + RAD_W'(ta_reg[m] >> FRAC_SH);
            rb = rb + RAD_W'(tb_reg[m] >> FRAC_SH);
        end
        rsum = RSUM_W'(ra) + RSUM_W'(rb);
        ovl  = $signed(OVL_W'(rsum)) - $signed(OVL_W'(len_reg));
        run_next = run_reg[4];
        if (!run_reg[4].apart && !skip_reg)
        begin
            if (ovl[OVL_W-1])
            begin
                run_next.apart = 1'b1;
            end
            else if (!run_reg[4].have || (ovl[BEST_W-1:0] < run_reg[4].best))
            begin
                run_next.have = 1'b1;
                run_next.best = ovl[BEST_W-1:0];
                run_next.idx  = axis_id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[CELL_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pair_reg[0] <= in_pair;
            run_reg[0]  <= in_run;
            for (int s = 1; s < CELL_STAGES - 1; s++)
            begin
                pair_reg[s] <= pair_reg[s-1];
                run_reg[s]  <= run_reg[s-1];
            end
            pair_reg[CELL_STAGES-1] <= pair_reg[CELL_STAGES-2];
            run_reg[CELL_STAGES-1]  <= run_next;
            xp_reg   <= xp_next;
            fvec_reg <= fvec_next;
            v_reg    <= v_next;
            sq_reg   <= sq_next;
            vdp_reg  <= vdp_next;
            adp_reg  <= adp_next;
            bdp_reg  <= bdp_next;
            lsq_reg  <= lsq_next;
            vd_reg   <= vd_next;
            adot_reg <= adot_next;
            bdot_reg <= bdot_next;
            skip_reg <= skip_next;
            len_reg  <= len_next;
            ta_reg   <= ta_next;
            tb_reg   <= tb_next;
        end
    end

    assign out_valid = vld_reg[CELL_STAGES-1];
    assign out_pair  = pair_reg[CELL_STAGES-1];
    assign out_run   = run_reg[CELL_STAGES-1];

endmodule

@@ rtl/obb_separating_axis_overlap.sv @@
// Channel   Valid          Stall          Payload
// input     pair_valid     pair_stall     pair   (obb_pkg::pair_in_t)
// output    result_valid   result_stall   result (obb_pkg::result_t)
//
// One box pair is accepted every cycle while the output side takes results.
// The path holds one input stage, fifteen six-stage axis cells,
// and the output register. Reset clears all valid bits; no clearing pass.
// A stalled result holds the whole chain, so the input stalls in the same cycle.
module obb_separating_axis_overlap (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pair_valid,
    output logic               pair_stall,
    input  obb_pkg::pair_in_t  pair,
    output logic               result_valid,
    input  logic               result_stall,
    output obb_pkg::result_t   result
);
    import obb_pkg::*;

    logic    adv;
    logic    chain_valid [NUM_AXES+1];
    pair_t   chain_pair  [NUM_AXES+1];
    run_t    chain_run   [NUM_AXES+1];
    logic    out_valid_reg;
    result_t out_reg;
    result_t out_next;

    assign adv        = !(out_valid_reg && result_stall);
    assign pair_stall = !adv;

    obb_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pair_valid),
        .in_data   (pair),
        .out_valid (chain_valid[0]),
        .out_pair  (chain_pair[0])
    );

    assign chain_run[0] = '{apart: 1'b0, have: 1'b0, best: '0, idx: '0};

    for (genvar n = 0; n < NUM_AXES; n++)
    begin : g_cell
        obb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .axis_id   (IDX_W'(n)),
            .in_valid  (chain_valid[n]),
            .in_pair   (chain_pair[n]),
            .in_run    (chain_run[n]),
            .out_valid (chain_valid[n+1]),
            .out_pair  (chain_pair[n+1]),
            .out_run   (chain_run[n+1])
        );
    end

    always_comb
    begin
        logic [BEST_W-DEPTH_SH-1:0] dq;
        run_t r;
        r        = chain_run[NUM_AXES];
        dq       = r.best[BEST_W-1:DEPTH_SH];
        out_next = '0;
        if (!r.apart)
        begin
            out_next.boxes_overlap = 1'b1;
            if (r.have)
            begin
                out_next.depth_valid    = 1'b1;
                out_next.min_axis_index = r.idx;
                if (|dq[BEST_W-DEPTH_SH-1:DEPTH_W])
                begin
                    out_next.min_depth = '1;
                end
                else
                begin
                    out_next.min_depth = dq[DEPTH_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= chain_valid[NUM_AXES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    logic unused_pair;
    assign unused_pair = ^chain_pair[NUM_AXES];

endmodule
